[hw/rtl/ihtab_pkg.sv]
// Shared types and constants for the id handle table.
`default_nettype none

package ihtab_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OCC_W       = 7;
    localparam int ID_W        = 32;
    localparam int HANDLE_W    = 64;

    // Request operation codes.
    typedef enum logic [1:0] {
        FUNC_LOOKUP   = 2'd0,
        FUNC_ALLOCATE = 2'd1,
        FUNC_RELEASE  = 2'd2
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_COMMIT = 2'd2
    } t_state;

    // Request word.
    typedef struct packed {
        t_func                  func;
        logic signed [ID_W-1:0] key_id;
        logic [HANDLE_W-1:0]    handle_in;
    } t_in_word;

    // Result word.
    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle_out;
        logic [OCC_W-1:0]    occupancy;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic search;
        logic commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

[hw/rtl/id_handle_table.sv]
// Top level of the id handle table.
//
// An ordered table of up to TABLE_DEPTH (id, handle) entries held in a chain of
// register cells. Allocate appends at the tail and is refused with a full status
// when every cell is taken; lookup returns the handle of the oldest entry with a
// matching id; release removes that entry and every later cell moves down one
// place, so age order is kept. Each request word returns one result word with a
// status and the occupancy after the request. A request passes a search state,
// in which every cell compares its id with the key, and a commit state, in
// which the oldest match is picked, the cells are updated and the result is
// registered; commit waits while a stalled output holds the result. The next
// request is accepted in the commit state; the result register frees the input
// side from a stalled output for one word. No clearing pass is needed after reset.
`default_nettype none

module id_handle_table
    import ihtab_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    t_dp_cmd          w_cmd;
    logic [CNT_W-1:0] w_count;

    // Sequencing of each request.
    ihtab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // Cell chain and result register.
    ihtab_cells u_cells (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word),
        .o_count    (w_count)
    );

    // The table never holds more entries than it has cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // A full refusal is only reported when every cell is occupied.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == ST_FULL))
            |-> (o_out_word.occupancy == OCC_W'(TABLE_DEPTH)))
        else $error("full status with free cells");

    // A failed request never carries a handle.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != ST_OK)) |-> (o_out_word.handle_out == '0))
        else $error("handle returned with failing status");

    // A result word is never overwritten while it is held by a stall.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> !(o_out_valid && i_out_stall))
        else $error("result register overwritten while stalled");

    // Occupancy changes only when a request completes.
    a_count_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cmd.commit |=> $stable(w_count))
        else $error("entry count changed without a commit");

endmodule

`default_nettype wire

[hw/rtl/ihtab_ctrl.sv]
// Controller state machine for the id handle table.
`default_nettype none

module ihtab_ctrl
    import ihtab_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire logic    i_out_stall,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // The result register can take a new word when empty or being drained.
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                // Finish the current word and take the next one in the same cycle.
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    o_in_stall   = 1'b0;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SEARCH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[hw/rtl/ihtab_cells.sv]
// Datapath of the id handle table: entry cells, match logic and result register.
`default_nettype none

module ihtab_cells
    import ihtab_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dp_cmd  i_cmd,
    input  wire t_in_word i_in_word,
    output t_out_word     o_out_word,
    output logic [CNT_W-1:0] o_count
);

    // Entry cells, ordered oldest first.
    logic signed [ID_W-1:0] r_cell_id     [TABLE_DEPTH];
    logic [HANDLE_W-1:0]    r_cell_handle [TABLE_DEPTH];

    t_in_word               r_req;
    logic [TABLE_DEPTH-1:0] r_match;
    logic [TABLE_DEPTH-1:0] n_match;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    t_out_word              r_out;
    t_out_word              n_out;

    logic [TABLE_DEPTH-1:0] w_at_or_after;
    logic [TABLE_DEPTH-1:0] w_first;
    logic [HANDLE_W-1:0]    w_sel_handle;
    logic                   w_hit;
    logic                   w_full;
    logic                   w_do_alloc;
    logic                   w_do_release;

    // Compare the key against every occupied cell.
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            n_match[i] = (r_cell_id[i] == r_req.key_id) && (CNT_W'(i) < r_count);
        end
    end

    // Prefix OR marks the oldest match and every cell after it.
    always_comb begin
        logic [TABLE_DEPTH-1:0] v;
        v = r_match;
        for (int s = 0; s < IDX_W; s++) begin
            v = v | (v << (2 ** s));
        end
        w_at_or_after = v;
    end

    assign w_first = w_at_or_after & ~{w_at_or_after[TABLE_DEPTH-2:0], 1'b0};
    assign w_hit   = w_at_or_after[TABLE_DEPTH-1];
    assign w_full  = (r_count == CNT_W'(TABLE_DEPTH));

    // One-hot select of the matched handle.
    always_comb begin
        w_sel_handle = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_sel_handle = w_sel_handle | ({HANDLE_W{w_first[i]}} & r_cell_handle[i]);
        end
    end

    assign w_do_alloc   = (r_req.func == FUNC_ALLOCATE) && !w_full;
    assign w_do_release = (r_req.func == FUNC_RELEASE) && w_hit;

    // Result word and next occupancy.
    always_comb begin
        n_count          = r_count;
        n_out.status     = ST_OK;
        n_out.handle_out = '0;
        case (r_req.func)
            FUNC_LOOKUP: begin
                if (w_hit) begin
                    n_out.handle_out = w_sel_handle;
                end else begin
                    n_out.status = ST_NOT_FOUND;
                end
            end
            FUNC_ALLOCATE: begin
                if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            FUNC_RELEASE: begin
                if (w_hit) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_out.status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
        n_out.occupancy = OCC_W'(n_count);
    end

    // Request, match vector and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_word;
        end
        if (i_cmd.search) begin
            r_match <= n_match;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    // Cell updates: append at the tail, or close the gap left by a release.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (w_do_alloc && (CNT_W'(i) == r_count)) begin
                    r_cell_id[i]     <= r_req.key_id;
                    r_cell_handle[i] <= r_req.handle_in;
                end else if (w_do_release && w_at_or_after[i] && (i < TABLE_DEPTH - 1)) begin
                    r_cell_id[i]     <= r_cell_id[(i + 1) % TABLE_DEPTH];
                    r_cell_handle[i] <= r_cell_handle[(i + 1) % TABLE_DEPTH];
                end
            end
        end
    end

    assign o_out_word = r_out;
    assign o_count    = r_count;

endmodule

`default_nettype wire
